### rtl/cgsd_pkg.sv
// Package for the chained gesture sequence detector: constants and shared types.
`timescale 1ns / 1ps

package cgsd_pkg;

    // Largest chain the detector walks; longer configured lengths are clamped
    localparam int MAX_STAGES = 8;

    // Field widths
    localparam int VALUE_W = 16;
    localparam int TIME_W  = 32;
    localparam int STAGE_W = 4;

    // Activation threshold, 1.0 in unsigned Q4.12
    localparam logic [VALUE_W-1:0] ONE_Q12 = 16'd4096;

    // Stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Configuration register indexes
    localparam logic REG_CHAIN_LENGTH = 1'b0;
    localparam logic REG_MAX_DELAY    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [STAGE_W-1:0] CHAIN_LENGTH_RST = 4'd0;
    localparam logic [TIME_W-1:0]  MAX_DELAY_RST    = 32'd1000;

    // Configuration seen by the update logic
    typedef struct packed {
        logic [STAGE_W-1:0] chain_length;
        logic [TIME_W-1:0]  max_delay;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic               chain_active;
        logic [STAGE_W-1:0] stage_now;
        logic [VALUE_W-1:0] result_value;
    } t_result;

endpackage

### rtl/chained_gesture_sequence_detector_top.sv
// Top level: stream ports, configuration registers, input and result registers.
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata[15:0] gesture_value, [47:16] now_ms
//  m_axis    | out       | tdata[15:0] result_value, [19:16] stage_now,
//            |           |      [20] chain_active, [23:21] zero
//  cfg write | in        | i_cfg_index 0 chain_length, 1 max_delay
//
// One transaction per cycle sustained while the output is not stalled; the input
// register loads at the accepting edge, and the update lands in the result
// register at the first edge at which that register is free.
// Reset is synchronous: chain state clears, chain_length 0, max_delay 1000.
// A stalled output holds its result; the input register still takes a new
// transaction while it is empty or the result register frees up in the same cycle.
`timescale 1ns / 1ps

module chained_gesture_sequence_detector_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // gesture_value, now_ms (from bit 0 up)
    input  logic [cgsd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // result_value, stage_now, chain_active, zero pad (from bit 0 up)
    output logic [cgsd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [cgsd_pkg::TIME_W-1:0]    i_cfg_data
);

    cgsd_pkg::t_cfg               r_cfg;
    logic                         r_in_valid;
    logic [cgsd_pkg::VALUE_W-1:0] r_in_value;
    logic [cgsd_pkg::TIME_W-1:0]  r_in_now;
    logic                         r_out_valid;
    cgsd_pkg::t_result            r_out;
    cgsd_pkg::t_result            w_result;
    logic                         w_out_free;
    logic                         w_step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chain_length <= cgsd_pkg::CHAIN_LENGTH_RST;
            r_cfg.max_delay    <= cgsd_pkg::MAX_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cgsd_pkg::REG_CHAIN_LENGTH: begin
                    r_cfg.chain_length <= i_cfg_data[cgsd_pkg::STAGE_W-1:0];
                end
                cgsd_pkg::REG_MAX_DELAY: begin
                    r_cfg.max_delay <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Flow control
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_value <= s_axis_tdata[cgsd_pkg::VALUE_W-1:0];
            r_in_now   <= s_axis_tdata[cgsd_pkg::VALUE_W +: cgsd_pkg::TIME_W];
        end
    end

    cgsd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (w_step),
        .i_value  (r_in_value),
        .i_now    (r_in_now),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.chain_active, r_out.stage_now, r_out.result_value};

endmodule

### rtl/cgsd_core.sv
// Chain state registers and the single-pass update for one gesture sample.
`timescale 1ns / 1ps

module cgsd_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cgsd_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [cgsd_pkg::VALUE_W-1:0] i_value,
    input  logic [cgsd_pkg::TIME_W-1:0]  i_now,
    output cgsd_pkg::t_result            o_result
);

    logic [cgsd_pkg::STAGE_W-1:0] r_stage_index, n_stage_index;
    logic                         r_fired, n_fired;
    logic                         r_held, n_held;
    logic                         r_wait_release, n_wait_release;
    logic [cgsd_pkg::TIME_W-1:0]  r_last_time, n_last_time;

    logic [cgsd_pkg::STAGE_W-1:0] w_len;
    logic [cgsd_pkg::TIME_W-1:0]  w_elapsed;
    logic                         w_active;
    logic                         w_edge;
    logic                         w_done;
    logic [cgsd_pkg::VALUE_W-1:0] w_res;

    // Effective chain length, clamped to the supported stage count
    always_comb begin
        if ({28'd0, i_cfg.chain_length} > 32'(cgsd_pkg::MAX_STAGES)) begin
            w_len = cgsd_pkg::STAGE_W'(cgsd_pkg::MAX_STAGES);
        end else begin
            w_len = i_cfg.chain_length;
        end
    end

    assign w_active  = (i_value >= cgsd_pkg::ONE_Q12);
    assign w_elapsed = i_now - r_last_time;  // wraps modulo 2^32

    // Next state and result for the sample
    always_comb begin
        n_stage_index  = r_stage_index;
        n_fired        = r_fired;
        n_held         = r_held;
        n_wait_release = r_wait_release;
        n_last_time    = r_last_time;
        w_res          = '0;
        w_done         = 1'b0;
        w_edge         = 1'b0;

        if (w_len == '0) begin
            // empty chain: state untouched
            w_done = 1'b1;
        end else if (r_stage_index >= w_len) begin
            // stale index after a shrinking length write
            n_stage_index  = '0;
            n_fired        = 1'b0;
            n_held         = 1'b0;
            n_wait_release = 1'b0;
            w_done         = 1'b1;
        end else if (r_wait_release) begin
            if (w_active) begin
                n_held = 1'b1;
                w_done = 1'b1;
            end else begin
                n_wait_release = 1'b0;
                n_held         = 1'b0;
            end
        end

        if (!w_done) begin
            w_edge = w_active && !n_held;
            n_held = w_active;

            if (!r_fired && (r_stage_index != '0) && (w_elapsed > i_cfg.max_delay)) begin
                // too slow between stages: back to the start
                n_stage_index  = '0;
                n_fired        = 1'b0;
                n_held         = 1'b0;
                n_wait_release = 1'b0;
            end else if (r_stage_index == w_len - 1'b1) begin
                // final stage: fire on edge, hold while active, restart on release
                if (w_edge) begin
                    n_fired = 1'b1;
                    w_res   = i_value;
                end else if (w_active && r_fired) begin
                    w_res = i_value;
                end else if (!w_active && r_fired) begin
                    n_stage_index  = '0;
                    n_fired        = 1'b0;
                    n_held         = 1'b0;
                    n_wait_release = 1'b0;
                end
            end else if (w_edge) begin
                n_stage_index  = r_stage_index + 1'b1;
                n_last_time    = i_now;
                n_held         = 1'b0;
                n_wait_release = 1'b1;
            end
        end
    end

    // State update, one sample per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_index  <= '0;
            r_fired        <= 1'b0;
            r_held         <= 1'b0;
            r_wait_release <= 1'b0;
            r_last_time    <= '0;
        end else if (i_step) begin
            r_stage_index  <= n_stage_index;
            r_fired        <= n_fired;
            r_held         <= n_held;
            r_wait_release <= n_wait_release;
            r_last_time    <= n_last_time;
        end
    end

    assign o_result.result_value = w_res;
    assign o_result.stage_now    = n_stage_index;
    assign o_result.chain_active = n_fired;

endmodule

### rtl/cgsd_checker.sv
// Port-level checker for the detector, bound to the top level.
`timescale 1ns / 1ps

module cgsd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic [cgsd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);

    // Output stream is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A nonzero result only comes from a fired final stage
    a_value_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[15:0] != '0)) |-> m_axis_tdata[20])
        else $error("nonzero result without chain_active");

    // A passed value is always an active one
    a_value_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[15:0] != '0))
            |-> (m_axis_tdata[15:0] >= cgsd_pkg::ONE_Q12))
        else $error("result below activation threshold");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind chained_gesture_sequence_detector_top cgsd_checker u_cgsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
